/* hw/rtl/grid_maze_dfs_path_search_macros.svh */
// Assertion macros shared by the grid maze search RTL.
// No dependencies; expects clk and arst_n in the enclosing module.
`ifndef GRID_MAZE_DFS_PATH_SEARCH_MACROS_SVH
`define GRID_MAZE_DFS_PATH_SEARCH_MACROS_SVH

// same-cycle implication
`define GMDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GMDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/gmds_pkg.sv */
// Constants for the grid maze depth-first search block.
// No dependencies.
package gmds_pkg;

	localparam int GRID_SIDE   = 8;
	localparam int STACK_DEPTH = 256;
	localparam int MAX_OUT     = 64;

	localparam int COORD_W = 3;
	localparam int CELL_W  = 2 * COORD_W;
	localparam int N_CELLS = 2 ** CELL_W;
	localparam int SP_W    = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = $clog2(STACK_DEPTH);
	localparam int CNT_W   = $clog2(MAX_OUT + 2);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

endpackage

/* hw/rtl/gmds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/grid_maze_dfs_path_search.sv */
// Grid maze depth-first search, top level.
// Depends on gmds_pkg, gmds_ram and grid_maze_dfs_path_search_macros.svh.
//
// Usage:
//  - Input channel (cmd_valid / cmd_stall) carries command, row, col, open.
//    A load (command 0) writes one cell of the open map;
//    loads may follow each other in every cycle and give no result.
//  - A search (command 1) names a target cell. The block runs a stack DFS
//    from cell (0,0) and holds cmd_stall high until its last result has been
//    placed in the output register.
//  - Result channel (res_valid / res_stall) gives path cells from the stack
//    top down with found = 1, or one not-found result; last marks the end.
//  - Search cost: each pop passes through POP and CHECK; each newly visited cell
//    adds the neighbor checks in NBR (one neighbor per cycle, one stack write port),
//    then two scans of the stack, each entry read in SCAN_RD and checked in SCAN_CK
//    (count pass, emit pass). The stack RAM's registered read sets these steps.
//  - A stalled receiver freezes the sequencer at the next result; the output
//    register holds its transfer until res_stall drops.
//  - Reset (arst_n low) clears the open map (all walls), visited map, stack
//    pointer and sequencer; stack contents stay undefined.

`include "grid_maze_dfs_path_search_macros.svh"

module grid_maze_dfs_path_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic                        command,
	input  logic [gmds_pkg::COORD_W-1:0] row,
	input  logic [gmds_pkg::COORD_W-1:0] col,
	input  logic                        open,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [gmds_pkg::COORD_W-1:0] path_row,
	output logic [gmds_pkg::COORD_W-1:0] path_col,
	output logic                        found,
	output logic                        truncated,
	output logic                        last
);
	import gmds_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_POP, ST_CHECK, ST_NBR, ST_SCAN_INIT, ST_SCAN_RD, ST_SCAN_CK, ST_NOT_FOUND
	} state_t;

	typedef enum logic [1:0] {DIR_RIGHT, DIR_DOWN, DIR_UP, DIR_LEFT} dir_t;

	localparam logic [COORD_W:0] GS_EXT  = (COORD_W + 1)'(GRID_SIDE);
	localparam logic [SP_W-1:0]  SP_FULL = SP_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_OUT + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OUT);

	state_t               state_q;
	dir_t                 dir_q;
	logic [N_CELLS-1:0]   open_q;
	logic [N_CELLS-1:0]   visited_q;
	logic [SP_W-1:0]      sp_q;
	logic [CELL_W-1:0]    cur_q;
	logic [CELL_W-1:0]    target_q;
	logic                 tgt_ok_q;
	logic                 ovf_q;
	logic                 pass_q;
	logic [ADDR_W-1:0]    scan_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     emit_cnt_q;

	logic                 out_valid_q;
	logic [COORD_W-1:0]   out_row_q;
	logic [COORD_W-1:0]   out_col_q;
	logic                 out_found_q;
	logic                 out_trunc_q;
	logic                 out_last_q;

	// stack RAM ports
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [CELL_W-1:0]    ram_wdata;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [CELL_W-1:0]    ram_rdata;

	logic                 in_xfer;
	logic                 out_free;
	logic                 row_ok;
	logic                 col_ok;
	logic [COORD_W-1:0]   cur_r;
	logic [COORD_W-1:0]   cur_c;
	logic [CELL_W-1:0]    nb;
	logic                 nb_ok;
	logic                 nb_push;
	logic                 sp_full;
	logic                 rd_hit;
	logic                 cur_hit;
	logic                 rd_vis;
	logic [CNT_W-1:0]     cnt_nx;
	logic                 emit_last;

	assign in_xfer  = cmd_valid && !cmd_stall;
	assign out_free = !out_valid_q || !res_stall;
	assign row_ok   = {1'b0, row} < GS_EXT;
	assign col_ok   = {1'b0, col} < GS_EXT;
	assign sp_full  = sp_q == SP_FULL;

	assign cur_r = cur_q[CELL_W-1:COORD_W];
	assign cur_c = cur_q[COORD_W-1:0];

	// one neighbor per cycle, right / down / up / left
	always_comb begin
		nb    = cur_q;
		nb_ok = 1'b0;
		unique case (dir_q)
			DIR_RIGHT: begin
				nb_ok = ({1'b0, cur_c} + 1'b1) < GS_EXT;
				nb    = {cur_r, cur_c + 1'b1};
			end
			DIR_DOWN: begin
				nb_ok = ({1'b0, cur_r} + 1'b1) < GS_EXT;
				nb    = {cur_r + 1'b1, cur_c};
			end
			DIR_UP: begin
				nb_ok = cur_r != '0;
				nb    = {cur_r - 1'b1, cur_c};
			end
			DIR_LEFT: begin
				nb_ok = cur_c != '0;
				nb    = {cur_r, cur_c - 1'b1};
			end
			default: begin
				nb_ok = 1'b0;
				nb    = cur_q;
			end
		endcase
	end

	assign nb_push = nb_ok && open_q[nb] && !visited_q[nb];
	assign rd_hit  = tgt_ok_q && (ram_rdata == target_q);
	assign cur_hit = tgt_ok_q && (cur_q == target_q);
	assign rd_vis  = visited_q[ram_rdata];
	assign cnt_nx  = (rd_vis && cnt_q != CNT_SAT) ? cnt_q + 1'b1 : cnt_q;
	assign emit_last = emit_cnt_q == (n_q - 1'b1);

	// stack write / read port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sp_q[ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = scan_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_we    = in_xfer && command == CMD_SEARCH;
				ram_waddr = '0;
				ram_wdata = '0;
			end
			ST_POP: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(sp_q - 1'b1);
			end
			ST_CHECK: begin
				ram_we    = !rd_vis;
				ram_wdata = ram_rdata;
			end
			ST_NBR: begin
				ram_we    = nb_push && !sp_full;
				ram_wdata = nb;
			end
			ST_SCAN_RD: begin
				ram_re = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
				ram_re = 1'b0;
			end
		endcase
	end

	gmds_ram #(
		.WIDTH (CELL_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dir_q       <= DIR_RIGHT;
			open_q      <= '0;
			visited_q   <= '0;
			sp_q        <= '0;
			cur_q       <= '0;
			ovf_q       <= 1'b0;
			pass_q      <= 1'b0;
			cnt_q       <= '0;
			n_q         <= '0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (command == CMD_LOAD) begin
							if (row_ok && col_ok) begin
								open_q[{row, col}] <= open;
							end
						end else begin
							visited_q <= '0;
							sp_q      <= SP_W'(1);
							ovf_q     <= 1'b0;
							target_q  <= {row, col};
							tgt_ok_q  <= row_ok && col_ok;
							state_q   <= ST_POP;
						end
					end
				end
				ST_POP: begin
					sp_q    <= sp_q - 1'b1;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cur_q <= ram_rdata;
					if (!rd_vis) begin
						// mark, push back, then try neighbors
						visited_q[ram_rdata] <= 1'b1;
						sp_q    <= sp_q + 1'b1;
						dir_q   <= DIR_RIGHT;
						state_q <= ST_NBR;
					end else if (rd_hit) begin
						state_q <= ST_SCAN_INIT;
					end else if (sp_q != '0) begin
						state_q <= ST_POP;
					end else begin
						state_q <= ST_NOT_FOUND;
					end
				end
				ST_NBR: begin
					if (nb_push) begin
						if (sp_full) begin
							ovf_q <= 1'b1;
						end else begin
							sp_q <= sp_q + 1'b1;
						end
					end
					dir_q <= dir_t'(dir_q + 1'b1);
					if (dir_q == DIR_LEFT) begin
						state_q <= cur_hit ? ST_SCAN_INIT : ST_POP;
					end
				end
				ST_SCAN_INIT: begin
					scan_q     <= ADDR_W'(sp_q - 1'b1);
					cnt_q      <= '0;
					emit_cnt_q <= '0;
					pass_q     <= 1'b0;
					state_q    <= ST_SCAN_RD;
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CK;
				end
				ST_SCAN_CK: begin
					if (!pass_q) begin
						// count pass: find result count and truncation first
						cnt_q <= cnt_nx;
						if (scan_q == '0) begin
							ovf_q   <= ovf_q || (cnt_nx > CNT_MAX);
							n_q     <= (cnt_nx > CNT_MAX) ? CNT_MAX : cnt_nx;
							pass_q  <= 1'b1;
							scan_q  <= ADDR_W'(sp_q - 1'b1);
						end else begin
							scan_q <= scan_q - 1'b1;
						end
						state_q <= ST_SCAN_RD;
					end else if (!rd_vis) begin
						scan_q  <= scan_q - 1'b1;
						state_q <= ST_SCAN_RD;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_row_q   <= ram_rdata[CELL_W-1:COORD_W];
						out_col_q   <= ram_rdata[COORD_W-1:0];
						out_found_q <= 1'b1;
						out_trunc_q <= ovf_q;
						out_last_q  <= emit_last;
						emit_cnt_q  <= emit_cnt_q + 1'b1;
						if (emit_last) begin
							sp_q    <= '0;
							state_q <= ST_IDLE;
						end else begin
							scan_q  <= scan_q - 1'b1;
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_NOT_FOUND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_row_q   <= '0;
						out_col_q   <= '0;
						out_found_q <= 1'b0;
						out_trunc_q <= ovf_q;
						out_last_q  <= 1'b1;
						sp_q        <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = state_q != ST_IDLE;
	assign res_valid = out_valid_q;
	assign path_row  = out_row_q;
	assign path_col  = out_col_q;
	assign found     = out_found_q;
	assign truncated = out_trunc_q;
	assign last      = out_last_q;

	// every search leaves an empty stack behind
	`GMDS_ASSERT_NOW(a_idle_stack_empty, state_q == ST_IDLE, sp_q == '0, "stack not empty in idle")
	// a search starts with only the start cell on the stack
	`GMDS_ASSERT_NEXT(a_search_start, in_xfer && command == CMD_SEARCH, sp_q == SP_W'(1) && state_q == ST_POP, "bad search start")
	// the emit pass never goes past the counted results
	`GMDS_ASSERT_NOW(a_emit_bound, state_q == ST_SCAN_CK && pass_q, emit_cnt_q < n_q && n_q <= CNT_MAX, "emit count past limit")
	// a not-found result is always the only and last one
	`GMDS_ASSERT_NOW(a_not_found_last, res_valid && !found, last && path_row == '0 && path_col == '0, "bad not-found result")

endmodule
